// ===== hw/rtl/rndis_packet_deframer_assert.svh =====
// assertion macros for the rndis packet deframer
`ifndef RNDIS_PACKET_DEFRAMER_ASSERT_SVH
`define RNDIS_PACKET_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define RPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RPD_ASSERT_IMP(lbl, ante, cons, msg)
`define RPD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/rpd_pkg.sv =====
// shared types and constants of the rndis packet deframer
package rpd_pkg;

    localparam int BufferBytes = 2048;
    localparam logic [16:0] BufferLimit = 17'(BufferBytes);

    localparam logic [31:0] PacketMsgCode = 32'd1;
    localparam logic [15:0] HeaderBytes   = 16'd44;
    localparam logic [31:0] PayloadBias   = 32'd8;

    localparam logic [15:0] PosTypeEnd   = 16'd3;
    localparam logic [15:0] PosLengthEnd = 16'd7;
    localparam logic [15:0] PosOffsetEnd = 16'd11;
    localparam logic [15:0] PosDlenEnd   = 16'd15;
    localparam logic [15:0] PosLastHdr   = 16'd43;

    localparam logic [15:0] MaxLenReset = 16'd2048;

    localparam logic CfgReceiveEnable   = 1'b0;
    localparam logic CfgMaxMessageLength = 1'b1;

    localparam logic KindPayload = 1'b0;
    localparam logic KindError   = 1'b1;

    typedef enum logic [1:0] {
        ErrNone   = 2'd0,
        ErrType   = 2'd1,
        ErrLength = 2'd2
    } t_err;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
        t_err       err;
    } t_entry;

    typedef struct packed {
        logic full;
        logic avail;
    } t_qstat;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

endpackage

// ===== hw/rtl/rpd_front.sv =====
// header parser and byte classifier of the rndis packet deframer
module rpd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output logic              o_cfg_ready,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_transfer_last,
    output logic              o_push,
    output rpd_pkg::t_entry   o_entry
);

    logic        r_rx_en;
    logic [15:0] r_max_len;
    logic [15:0] r_pos, n_pos;
    logic [31:0] r_header_shift, n_header_shift;
    logic [15:0] r_message_length, n_message_length;
    logic [31:0] r_payload_start, n_payload_start;
    logic [15:0] r_payload_end, n_payload_end;
    logic        r_drop, n_drop;

    logic [31:0]   shift_new;
    logic [16:0]   pos_inc;
    logic          in_header;
    logic [32:0]   off_sum;
    logic [31:0]   start_sat;
    logic [32:0]   end_sum;
    logic          in_payload;
    logic          wrap;
    rpd_pkg::t_err err;

    assign o_cfg_ready = 1'b1;

    assign shift_new = {i_data_byte, r_header_shift[31:8]};
    assign pos_inc   = {1'b0, r_pos} + 17'd1;
    assign in_header = r_pos < rpd_pkg::HeaderBytes;
    assign off_sum   = {1'b0, shift_new} + {1'b0, rpd_pkg::PayloadBias};
    assign start_sat = off_sum[32] ? 32'hFFFF_FFFF : off_sum[31:0];
    // data length is the last header field parsed; the end is fixed here once per message
    assign end_sum   = {1'b0, r_payload_start} + {1'b0, shift_new};
    assign in_payload = ({16'd0, r_pos} >= r_payload_start) && (r_pos < r_payload_end);
    assign wrap = (r_pos >= rpd_pkg::PosLastHdr) && (pos_inc >= {1'b0, r_message_length});

    always_comb begin
        n_pos            = r_pos;
        n_header_shift   = r_header_shift;
        n_message_length = r_message_length;
        n_payload_start  = r_payload_start;
        n_payload_end    = r_payload_end;
        n_drop           = r_drop;
        err              = rpd_pkg::ErrNone;
        o_push           = 1'b0;
        o_entry.kind     = rpd_pkg::KindPayload;
        o_entry.data     = i_data_byte;
        o_entry.last     = pos_inc == {1'b0, r_payload_end};
        o_entry.err      = rpd_pkg::ErrNone;
        if (i_accept && r_rx_en) begin
            if (r_drop) begin
                if (i_transfer_last) begin
                    n_drop = 1'b0;
                    n_pos  = 16'd0;
                end
            end else begin
                if (in_header) begin
                    n_header_shift = shift_new;
                    priority if (r_pos == rpd_pkg::PosTypeEnd) begin
                        if (shift_new != rpd_pkg::PacketMsgCode) err = rpd_pkg::ErrType;
                    end else if (r_pos == rpd_pkg::PosLengthEnd) begin
                        n_message_length = shift_new[15:0];
                        if (shift_new < {16'd0, rpd_pkg::HeaderBytes} ||
                            shift_new > {16'd0, r_max_len} ||
                            shift_new > {15'd0, rpd_pkg::BufferLimit})
                            err = rpd_pkg::ErrLength;
                    end else if (r_pos == rpd_pkg::PosOffsetEnd) begin
                        n_payload_start = (start_sat < {16'd0, rpd_pkg::HeaderBytes}) ?
                                          {16'd0, rpd_pkg::HeaderBytes} : start_sat;
                    end else if (r_pos == rpd_pkg::PosDlenEnd) begin
                        n_payload_end = (end_sum > {17'd0, r_message_length}) ?
                                        r_message_length : end_sum[15:0];
                    end else begin
                        err = rpd_pkg::ErrNone;
                    end
                end else if (in_payload) begin
                    o_push = 1'b1;
                end
                if (err != rpd_pkg::ErrNone) begin
                    o_push       = 1'b1;
                    o_entry.kind = rpd_pkg::KindError;
                    o_entry.data = 8'd0;
                    o_entry.last = 1'b0;
                    o_entry.err  = err;
                    n_pos        = 16'd0;
                    n_drop       = !i_transfer_last;
                end else begin
                    n_pos = wrap ? 16'd0 : pos_inc[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_en          <= 1'b0;
            r_max_len        <= rpd_pkg::MaxLenReset;
            r_pos            <= 16'd0;
            r_header_shift   <= 32'd0;
            r_message_length <= 16'd0;
            r_payload_start  <= 32'd0;
            r_payload_end    <= 16'd0;
            r_drop           <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rpd_pkg::CfgReceiveEnable:    r_rx_en   <= i_cfg_data[0];
                    rpd_pkg::CfgMaxMessageLength: r_max_len <= i_cfg_data;
                endcase
            end
            r_pos            <= n_pos;
            r_header_shift   <= n_header_shift;
            r_message_length <= n_message_length;
            r_payload_start  <= n_payload_start;
            r_payload_end    <= n_payload_end;
            r_drop           <= n_drop;
        end
    end

endmodule

// ===== hw/rtl/rpd_queue.sv =====
// short word queue between parser and output stage
module rpd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rpd_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output rpd_pkg::t_qstat   o_stat,
    output rpd_pkg::t_entry   o_head
);

    rpd_pkg::t_entry           r_mem [rpd_pkg::QDepth];
    logic [rpd_pkg::QPtrW-1:0] r_wr_ptr;
    logic [rpd_pkg::QPtrW-1:0] r_rd_ptr;
    logic [rpd_pkg::QCntW-1:0] r_cnt;

    logic do_pop;

    assign o_stat.full  = r_cnt == rpd_pkg::QCntW'(rpd_pkg::QDepth);
    assign o_stat.avail = r_cnt != '0;
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_stat.avail;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            unique case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/rpd_back.sv =====
// output register stage that hands results to the consumer
module rpd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpd_pkg::t_qstat   i_stat,
    input  rpd_pkg::t_entry   i_head,
    output logic              o_load,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_item_kind,
    output logic [7:0]        o_payload_byte,
    output logic              o_frame_last,
    output logic [1:0]        o_error_code
);

    logic            r_valid;
    rpd_pkg::t_entry r_entry;

    // refill when empty or when the held word leaves this cycle
    assign o_load = i_stat.avail && (!r_valid || i_pop);

    assign o_empty        = !r_valid;
    assign o_item_kind    = r_entry.kind;
    assign o_payload_byte = r_entry.data;
    assign o_frame_last   = r_entry.last;
    assign o_error_code   = 2'(r_entry.err);

    always_ff @(posedge i_clk) begin
        if (o_load) r_entry <= i_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== hw/rtl/rndis_packet_deframer.sv =====
// top level of the rndis packet deframer
// a byte that yields a result is written into the queue, then loaded into the output register once it is free
// throughput: one byte per cycle while full is low, held by a four-word queue and one output register
// full rises only when the queue holds four words the consumer has not taken
// reset: synchronous active low; parser state cleared, receive off, limit 2048, queue empty
module rndis_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_cfg_ready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_transfer_last,
    output logic        empty,
    input  logic        pop,
    output logic        o_item_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_frame_last,
    output logic [1:0]  o_error_code
);

`include "rndis_packet_deframer_assert.svh"

    logic            accept;
    logic            front_push;
    rpd_pkg::t_entry front_entry;
    rpd_pkg::t_qstat qstat;
    rpd_pkg::t_entry qhead;
    logic            back_load;

    assign full   = qstat.full;
    assign accept = push && !qstat.full;

    rpd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_transfer_last(i_transfer_last),
        .o_push         (front_push),
        .o_entry        (front_entry)
    );

    rpd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_entry(front_entry),
        .i_pop  (back_load),
        .o_stat (qstat),
        .o_head (qhead)
    );

    rpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stat        (qstat),
        .i_head        (qhead),
        .o_load        (back_load),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_item_kind   (o_item_kind),
        .o_payload_byte(o_payload_byte),
        .o_frame_last  (o_frame_last),
        .o_error_code  (o_error_code)
    );

    `RPD_ASSERT_IMP(a_push_only_on_accept, front_push, accept, "queue write without accepted byte")
    `RPD_ASSERT_NXT(a_back_refills, empty && qstat.avail, !empty, "output stage idle with queued word")
    `RPD_ASSERT_IMP(a_error_word_clean, !empty && o_item_kind, (o_payload_byte == 8'd0) && !o_frame_last, "error word carries payload bits")
    `RPD_ASSERT_IMP(a_full_has_data, qstat.full, qstat.avail, "queue full but empty")

endmodule
